// ----- sv/yrc_pkg.sv -----
// Package: payload types, chroma scale constants and shared widths for the YUV420 to RGB565 block.
package yrc_pkg;

  localparam int unsigned LumaWidth  = 8;
  localparam int unsigned TermWidth  = 10;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CoefWidth  = 17;
  localparam int unsigned PixWidth   = 16;

  // Coefficients in 1.16 fixed point, rounded to nearest. With |c| <= 128 the
  // error stays under 1/1000, below the 1/250 gap of the exact products to any
  // integer, so truncation matches the exact quotient.
  localparam logic [CoefWidth-1:0] KUb = 17'd116130;  // 1.772
  localparam logic [CoefWidth-1:0] KUg = 17'd22554;   // 0.34414
  localparam logic [CoefWidth-1:0] KVg = 17'd46802;   // 0.71414
  localparam logic [CoefWidth-1:0] KVr = 17'd91881;   // 1.402

  localparam logic [7:0] MaskR = 8'hF8;
  localparam logic [7:0] MaskG = 8'hFC;
  localparam logic [4:0] MaskB = 5'h1F;

  typedef struct packed {
    logic [LumaWidth-1:0] luma_top_left;
    logic [LumaWidth-1:0] luma_top_right;
    logic [LumaWidth-1:0] luma_bottom_left;
    logic [LumaWidth-1:0] luma_bottom_right;
    logic [LumaWidth-1:0] chroma_blue;
    logic [LumaWidth-1:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [31:0] top_pair;
    logic [31:0] bottom_pair;
  } out_t;

  // Chroma contributions shared by the four lanes.
  typedef struct packed {
    logic signed [TermWidth-1:0] ub;
    logic signed [TermWidth-1:0] gsub;
    logic signed [TermWidth-1:0] vr;
  } chroma_terms_t;

endpackage

// ----- sv/yuv420_to_rgb565_converter.sv -----
// Top level: 2x2 YUV420 block to four RGB565 pixels, two-stage pipeline.
//
//  Channel  Ports                         Payload          Moves per request
//  in       in_valid/in_ready/in_data     yrc_pkg::in_t    one 2x2 block, shared U,V
//  out      out_valid/out_ready/out_data  yrc_pkg::out_t   top and bottom pixel pairs
//
// Blocks pass stage 1 and the output register; one per clock while out_ready is high.
// Stage 1 registers the lumas with the scaled chroma terms (constant multipliers);
// stage 2 runs four pixel lanes and merges them into the output register.
// Reset (rst_n low, synchronous) empties both stages; payload is not cleared.
// A stall on out_ready holds the result; stage 1 still fills, so one more
// request is taken before in_ready drops.
module yuv420_to_rgb565_converter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  yrc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output yrc_pkg::out_t out_data
);

  // Stage 1 state
  logic                          s1_valid_r, s1_valid_nxt;
  logic [yrc_pkg::LumaWidth-1:0] s1_luma_r [4];
  yrc_pkg::chroma_terms_t        s1_terms_r;
  yrc_pkg::chroma_terms_t        terms_nxt;
  logic                          s1_ready;

  // Output stage
  logic          out_valid_r, out_valid_nxt;
  yrc_pkg::out_t out_data_r, out_data_nxt;

  logic [yrc_pkg::PixWidth-1:0] pix [4];

  // Stage 1 moves on when the output register is empty or being drained.
  assign s1_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_ready;

  // Chroma terms are computed once per block and shared by all lanes.
  yrc_chroma u_chroma (
    .chroma_blue (in_data.chroma_blue),
    .chroma_red  (in_data.chroma_red),
    .terms       (terms_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_luma_r[0] <= in_data.luma_top_left;
      s1_luma_r[1] <= in_data.luma_top_right;
      s1_luma_r[2] <= in_data.luma_bottom_left;
      s1_luma_r[3] <= in_data.luma_bottom_right;
      s1_terms_r   <= terms_nxt;
    end
  end

  // Four pixel lanes: TL, TR, BL, BR.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    yrc_lane u_lane (
      .luma  (s1_luma_r[i]),
      .terms (s1_terms_r),
      .pixel (pix[i])
    );
  end

  // Merge: left pixel in the low half of each row word.
  assign out_data_nxt.top_pair    = {pix[1], pix[0]};
  assign out_data_nxt.bottom_pair = {pix[3], pix[2]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Accepted request lands in stage 1.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted request did not reach stage 1");

  // Stage 1 holds its block while the output register is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> s1_valid_r)
    else $error("stage 1 block dropped under stall");

  // Stage 1 advancing always fills the output register.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ready) |=> out_valid_r)
    else $error("stage 1 advance lost");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// ----- sv/yrc_chroma.sv -----
// Chroma scaling: centers U and V and forms the blue, green and red offsets.
module yrc_chroma (
  input  logic [yrc_pkg::LumaWidth-1:0] chroma_blue,
  input  logic [yrc_pkg::LumaWidth-1:0] chroma_red,
  output yrc_pkg::chroma_terms_t        terms
);

  localparam int unsigned ProdWidth = yrc_pkg::LumaWidth + yrc_pkg::CoefWidth;

  logic                 u_neg, v_neg;
  logic [7:0]           u_mag, v_mag;
  logic [ProdWidth-1:0] p_ub, p_ug, p_vg, p_vr;
  logic [8:0]           m_ub, m_ug, m_vg, m_vr;
  logic signed [yrc_pkg::TermWidth-1:0] s_ub, s_ug, s_vg, s_vr;

  // Sign and magnitude of c - 128; magnitude tops out at 128.
  assign u_neg = ~chroma_blue[7];
  assign v_neg = ~chroma_red[7];
  assign u_mag = u_neg ? (8'd128 - {1'b0, chroma_blue[6:0]}) : {1'b0, chroma_blue[6:0]};
  assign v_mag = v_neg ? (8'd128 - {1'b0, chroma_red[6:0]})  : {1'b0, chroma_red[6:0]};

  assign p_ub = ProdWidth'(u_mag) * ProdWidth'(yrc_pkg::KUb);
  assign p_ug = ProdWidth'(u_mag) * ProdWidth'(yrc_pkg::KUg);
  assign p_vg = ProdWidth'(v_mag) * ProdWidth'(yrc_pkg::KVg);
  assign p_vr = ProdWidth'(v_mag) * ProdWidth'(yrc_pkg::KVr);

  // Truncating the magnitude then restoring the sign rounds toward zero.
  assign m_ub = p_ub[yrc_pkg::FracBits +: 9];
  assign m_ug = p_ug[yrc_pkg::FracBits +: 9];
  assign m_vg = p_vg[yrc_pkg::FracBits +: 9];
  assign m_vr = p_vr[yrc_pkg::FracBits +: 9];

  assign s_ub = u_neg ? -$signed({1'b0, m_ub}) : $signed({1'b0, m_ub});
  assign s_ug = u_neg ? -$signed({1'b0, m_ug}) : $signed({1'b0, m_ug});
  assign s_vg = v_neg ? -$signed({1'b0, m_vg}) : $signed({1'b0, m_vg});
  assign s_vr = v_neg ? -$signed({1'b0, m_vr}) : $signed({1'b0, m_vr});

  assign terms.ub   = s_ub;
  assign terms.gsub = s_ug + s_vg;
  assign terms.vr   = s_vr;

endmodule

// ----- sv/yrc_lane.sv -----
// Pixel lane: adds chroma offsets to one luma sample, clamps and packs RGB565.
module yrc_lane (
  input  logic [yrc_pkg::LumaWidth-1:0] luma,
  input  yrc_pkg::chroma_terms_t        terms,
  output logic [yrc_pkg::PixWidth-1:0]  pixel
);

  localparam int unsigned SumWidth = yrc_pkg::TermWidth + 1;

  logic signed [SumWidth-1:0] y_s, r_s, g_s, b_s;
  logic [7:0] r_c, g_c, b_c;

  function automatic logic [7:0] clamp8(input logic signed [SumWidth-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > SumWidth'(255)) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  assign y_s = $signed({{(SumWidth-yrc_pkg::LumaWidth){1'b0}}, luma});
  assign r_s = y_s + SumWidth'(terms.vr);
  assign g_s = y_s - SumWidth'(terms.gsub);
  assign b_s = y_s + SumWidth'(terms.ub);

  assign r_c = clamp8(r_s) & yrc_pkg::MaskR;
  assign g_c = clamp8(g_s) & yrc_pkg::MaskG;
  assign b_c = clamp8(b_s);

  assign pixel = {r_c[7:3], g_c[7:2], b_c[7:3] & yrc_pkg::MaskB};

endmodule
